// ===== hw/rtl/psle_pkg.sv =====
// Package: shared constants and types for the Phong specular lobe evaluator.
`timescale 1ns / 1ps

package psle_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LobeExpW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEC_GAIN   = 3'd0,
    CFG_COLOUR_RED  = 3'd1,
    CFG_COLOUR_GRN  = 3'd2,
    CFG_COLOUR_BLU  = 3'd3,
    CFG_LOBE_EXP    = 3'd4
  } cfg_idx_e;

  typedef logic signed [CompW-1:0] comp_t;

endpackage

// ===== hw/rtl/psle_if.sv =====
// Interfaces: input vector channel and RGB result channel with valid/ready.
`timescale 1ns / 1ps

interface psle_in_if;
  logic            valid;
  logic            ready;
  psle_pkg::comp_t normal_x;
  psle_pkg::comp_t normal_y;
  psle_pkg::comp_t normal_z;
  psle_pkg::comp_t incoming_x;
  psle_pkg::comp_t incoming_y;
  psle_pkg::comp_t incoming_z;
  psle_pkg::comp_t outgoing_x;
  psle_pkg::comp_t outgoing_y;
  psle_pkg::comp_t outgoing_z;

  modport source (output valid, normal_x, normal_y, normal_z, incoming_x, incoming_y,
                  incoming_z, outgoing_x, outgoing_y, outgoing_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, incoming_x, incoming_y,
                incoming_z, outgoing_x, outgoing_y, outgoing_z, output ready);
endinterface

interface psle_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic        lobe_lit;

  modport source (output valid, red_out, green_out, blue_out, lobe_lit, input ready);
  modport sink (input valid, red_out, green_out, blue_out, lobe_lit, output ready);
endinterface

// ===== hw/rtl/phong_specular_lobe_eval.sv =====
// Phong specular lobe evaluator: mirror, dot, power and colour scaling pipeline.
// Throughput: one item per cycle; the exponent takes one square and one multiply
// stage per bit, and a stall at the output holds every stage at once.
// Reset: asynchronous, active low; clears all valid bits and sets the registers
// to gain 0, colours 1.0 and exponent 1.
`timescale 1ns / 1ps

module phong_specular_lobe_eval #(
  parameter int unsigned FRAC_BITS = 15,
  parameter int unsigned EXP_BITS  = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psle_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [psle_pkg::CfgW-1:0]        cfg_data_i,
  psle_in_if.sink                          in_i,
  psle_out_if.source                       out_o
);

  localparam int unsigned PW  = FRAC_BITS + 1;
  localparam int unsigned RW  = (52 - 2 * FRAC_BITS > 18) ? 52 - 2 * FRAC_BITS : 18;
  localparam int unsigned TW  = RW + 16;
  localparam int unsigned DW  = RW + 18;
  localparam int unsigned GW  = 33 - FRAC_BITS;
  localparam int unsigned VW  = 35 - FRAC_BITS;
  localparam int unsigned NPS = 2 * EXP_BITS;
  localparam int unsigned NS  = 8 + NPS;
  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF64 = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] SAT64 = (FRAC_BITS >= 16) ? 64'hFFFF : ONE64;
  localparam logic [PW-1:0] ONE_P = PW'(ONE64);

  function automatic logic signed [63:0] rnd64(logic signed [63:0] v, int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic logic [PW-1:0] fmulp(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [2*PW-1:0] pr;
    pr = (2*PW)'(a) * (2*PW)'(b) + (2*PW)'(HALF64);
    return pr[FRAC_BITS +: PW];
  endfunction

  // configuration registers
  logic [15:0] gain_q, red_q, grn_q, blu_q;
  logic [psle_pkg::LobeExpW-1:0] lexp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd0;
      red_q  <= 16'd32768;
      grn_q  <= 16'd32768;
      blu_q  <= 16'd32768;
      lexp_q <= psle_pkg::LobeExpW'(1);
    end else if (cfg_we_i) begin
      unique case (psle_pkg::cfg_idx_e'(cfg_idx_i))
        psle_pkg::CFG_SPEC_GAIN:  gain_q <= cfg_data_i;
        psle_pkg::CFG_COLOUR_RED: red_q  <= cfg_data_i;
        psle_pkg::CFG_COLOUR_GRN: grn_q  <= cfg_data_i;
        psle_pkg::CFG_COLOUR_BLU: blu_q  <= cfg_data_i;
        psle_pkg::CFG_LOBE_EXP:   lexp_q <= cfg_data_i[psle_pkg::LobeExpW-1:0];
        default: ;
      endcase
    end
  end

  logic [EXP_BITS+psle_pkg::LobeExpW-1:0] exp_ext;
  logic [EXP_BITS-1:0] exp_eff;
  assign exp_ext = {{EXP_BITS{1'b0}}, lexp_q};
  assign exp_eff = exp_ext[EXP_BITS-1:0];

  // gain times colour, refreshed every cycle from the registers
  logic [GW-1:0] gc_q [3];
  logic [32:0]   gcp [3];
  assign gcp[0] = 33'(gain_q) * 33'(red_q) + 33'(HALF64);
  assign gcp[1] = 33'(gain_q) * 33'(grn_q) + 33'(HALF64);
  assign gcp[2] = 33'(gain_q) * 33'(blu_q) + 33'(HALF64);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      gc_q[i] <= gcp[i][FRAC_BITS +: GW];
    end
  end

  // global advance: every stage moves when the output slot is free
  logic [NS-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  // stage 1: n.wi products
  psle_pkg::comp_t n_in [3], wi_in [3], wo_in [3];
  assign n_in[0]  = in_i.normal_x;
  assign n_in[1]  = in_i.normal_y;
  assign n_in[2]  = in_i.normal_z;
  assign wi_in[0] = in_i.incoming_x;
  assign wi_in[1] = in_i.incoming_y;
  assign wi_in[2] = in_i.incoming_z;
  assign wo_in[0] = in_i.outgoing_x;
  assign wo_in[1] = in_i.outgoing_y;
  assign wo_in[2] = in_i.outgoing_z;

  logic signed [31:0] prod1_q [3];
  psle_pkg::comp_t n1_q [3], wi1_q [3], wo1_q [3];
  logic signed [33:0] pdot2_q;
  psle_pkg::comp_t n2_q [3], wi2_q [3], wo2_q [3];
  logic signed [49:0] m3_q [3];
  psle_pkg::comp_t wi3_q [3], wo3_q [3];
  logic signed [RW-1:0] r4_q [3];
  psle_pkg::comp_t wo4_q [3];
  logic signed [TW-1:0] t5_q [3];
  logic          lit6_q;
  logic [PW-1:0] p6_q;

  logic signed [63:0] r_full [3];
  logic signed [DW-1:0] dsum;
  logic signed [63:0] dround;
  logic [PW-1:0] p_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_full[i] = rnd64(64'(m3_q[i]), 2 * FRAC_BITS - 1) - 64'(wi3_q[i]);
    end
    dsum = DW'(t5_q[0]) + DW'(t5_q[1]) + DW'(t5_q[2]);
    dround = rnd64(64'(dsum), FRAC_BITS);
    p_d = (dround > $signed(ONE64)) ? ONE_P : dround[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= n_in[i] * wi_in[i];
        n1_q[i]    <= n_in[i];
        wi1_q[i]   <= wi_in[i];
        wo1_q[i]   <= wo_in[i];
        n2_q[i]    <= n1_q[i];
        wi2_q[i]   <= wi1_q[i];
        wo2_q[i]   <= wo1_q[i];
        // 2*n*P is folded into the rounding shift
        m3_q[i]    <= 50'(n2_q[i]) * 50'(pdot2_q);
        wi3_q[i]   <= wi2_q[i];
        wo3_q[i]   <= wo2_q[i];
        r4_q[i]    <= r_full[i][RW-1:0];
        wo4_q[i]   <= wo3_q[i];
        t5_q[i]    <= TW'(r4_q[i]) * TW'(wo4_q[i]);
      end
      pdot2_q <= 34'(prod1_q[0]) + 34'(prod1_q[1]) + 34'(prod1_q[2]);
      lit6_q  <= dsum > 0;
      p6_q    <= p_d;
    end
  end

  // power stages: even stage squares, odd stage multiplies by p when the bit is set
  logic [PW-1:0] pw_q [NPS];
  logic [PW-1:0] pp_q [NPS];
  logic          pl_q [NPS];

  for (genvar k = 0; k < NPS; k++) begin : g_pow
    logic [PW-1:0] src, base, pw_d;
    logic          lsrc;
    if (k == 0) begin : g_first
      assign src  = ONE_P;
      assign base = p6_q;
      assign lsrc = lit6_q;
    end else begin : g_next
      assign src  = pw_q[k-1];
      assign base = pp_q[k-1];
      assign lsrc = pl_q[k-1];
    end
    if (k % 2 == 0) begin : g_sq
      assign pw_d = fmulp(src, src);
    end else begin : g_mul
      assign pw_d = exp_eff[EXP_BITS-1-k/2] ? fmulp(src, base) : src;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pw_q[k] <= pw_d;
        pp_q[k] <= base;
        pl_q[k] <= lsrc;
      end
    end
  end

  // channel scaling, then saturate and mask
  logic [VW-1:0] cv_q [3];
  logic          lc_q;
  logic [34:0]   cvp [3];
  logic [15:0]   ch_d [3];
  logic [15:0]   ch_q [3];
  logic          lo_q;
  logic [63:0]   cv64 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cvp[i]  = 35'(gc_q[i]) * 35'(pw_q[NPS-1]) + 35'(HALF64);
      cv64[i] = 64'(cv_q[i]);
      ch_d[i] = !lc_q ? 16'd0 : (cv64[i] > SAT64) ? SAT64[15:0] : cv64[i][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cv_q[i] <= cvp[i][FRAC_BITS +: VW];
        ch_q[i] <= ch_d[i];
      end
      lc_q <= pl_q[NPS-1];
      lo_q <= lc_q;
    end
  end

  assign out_o.valid     = vld_q[NS-1];
  assign out_o.red_out   = ch_q[0];
  assign out_o.green_out = ch_q[1];
  assign out_o.blue_out  = ch_q[2];
  assign out_o.lobe_lit  = lo_q;

endmodule

// ===== test/testbench.sv =====
// Testbench: random and directed checks of the Phong specular lobe evaluator against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam longint OneQ = 64'd32768;
  localparam int FracW = 15;
  localparam int ExpW = 10;
  localparam int DrainCycles = 40;
  localparam int StallLimit = 4000;
  localparam logic [psle_pkg::CfgIdxW-1:0] CfgIdxUnusedA = 3'd5;
  localparam logic [psle_pkg::CfgIdxW-1:0] CfgIdxUnusedB = 3'd7;

  typedef struct {
    psle_pkg::comp_t nx, ny, nz, ix, iy, iz, ox, oy, oz;
  } lobe_query_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        lit;
  } lobe_color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [psle_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [psle_pkg::CfgW-1:0] cfg_data_i = '0;

  psle_in_if in_if ();
  psle_out_if out_if ();

  phong_specular_lobe_eval dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers
  longint gain_q = 0;
  longint red_q = 32768;
  longint green_q = 32768;
  longint blue_q = 32768;
  longint lobe_exp_q = 1;

  lobe_query_t query_queue[$];
  lobe_color_t color_queue[$];
  lobe_query_t query_on_bus;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_sender = 1'b0;
  int errors = 0;
  int queries_sent = 0;
  int colors_seen = 0;
  int lit_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  function automatic longint round_div(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (longint'(1) << (FracW - 1))) >>> FracW;
  endfunction

  function automatic lobe_color_t shade_lobe(lobe_query_t q);
    lobe_color_t c;
    longint n[3], wi[3], wo[3], r[3];
    longint ndot, rdot, base, pw, v;
    longint cols[3];
    n = '{q.nx, q.ny, q.nz};
    wi = '{q.ix, q.iy, q.iz};
    wo = '{q.ox, q.oy, q.oz};
    ndot = n[0] * wi[0] + n[1] * wi[1] + n[2] * wi[2];
    for (int i = 0; i < 3; i++) r[i] = -wi[i] + round_div(2 * n[i] * ndot, 2 * FracW);
    rdot = r[0] * wo[0] + r[1] * wo[1] + r[2] * wo[2];
    c = '{16'd0, 16'd0, 16'd0, 1'b0};
    if (rdot <= 0) return c;
    base = round_div(rdot, FracW);
    if (base > OneQ) base = OneQ;
    pw = OneQ;
    for (int b = ExpW - 1; b >= 0; b--) begin
      pw = qmul(pw, pw);
      if (lobe_exp_q[b]) pw = qmul(pw, base);
    end
    cols = '{red_q, green_q, blue_q};
    for (int i = 0; i < 3; i++) begin
      v = qmul(qmul(gain_q, cols[i]), pw);
      if (v > OneQ) v = OneQ;
      cols[i] = v;
    end
    c.red = cols[0][15:0];
    c.green = cols[1][15:0];
    c.blue = cols[2][15:0];
    c.lit = 1'b1;
    return c;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        color_queue.push_back(shade_lobe(query_on_bus));
        queries_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (!hold_sender && query_queue.size() > 0 &&
            $urandom_range(99) >= src_idle_pct) begin
          query_on_bus = query_queue.pop_front();
          in_if.normal_x <= query_on_bus.nx;
          in_if.normal_y <= query_on_bus.ny;
          in_if.normal_z <= query_on_bus.nz;
          in_if.incoming_x <= query_on_bus.ix;
          in_if.incoming_y <= query_on_bus.iy;
          in_if.incoming_z <= query_on_bus.iz;
          in_if.outgoing_x <= query_on_bus.ox;
          in_if.outgoing_y <= query_on_bus.oy;
          in_if.outgoing_z <= query_on_bus.oz;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    lobe_color_t exp_c;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (color_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          exp_c = color_queue.pop_front();
          colors_seen++;
          if (exp_c.lit) lit_seen++;
          if (out_if.red_out !== exp_c.red) begin
            $error("red_out: expected %0d, got %0d", exp_c.red, out_if.red_out);
            errors++;
          end
          if (out_if.green_out !== exp_c.green) begin
            $error("green_out: expected %0d, got %0d", exp_c.green, out_if.green_out);
            errors++;
          end
          if (out_if.blue_out !== exp_c.blue) begin
            $error("blue_out: expected %0d, got %0d", exp_c.blue, out_if.blue_out);
            errors++;
          end
          if (out_if.lobe_lit !== exp_c.lit) begin
            $error("lobe_lit: expected %0d, got %0d", exp_c.lit, out_if.lobe_lit);
            errors++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("phong_specular_lobe_eval test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [psle_pkg::CfgIdxW-1:0] idx,
                           logic [psle_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      psle_pkg::CFG_SPEC_GAIN:  gain_q = data;
      psle_pkg::CFG_COLOUR_RED: red_q = data;
      psle_pkg::CFG_COLOUR_GRN: green_q = data;
      psle_pkg::CFG_COLOUR_BLU: blue_q = data;
      psle_pkg::CFG_LOBE_EXP:   lobe_exp_q = data[psle_pkg::LobeExpW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_lobe(longint g, longint r, longint gr, longint b, longint e);
    write_reg(psle_pkg::CFG_SPEC_GAIN, g[15:0]);
    write_reg(psle_pkg::CFG_COLOUR_RED, r[15:0]);
    write_reg(psle_pkg::CFG_COLOUR_GRN, gr[15:0]);
    write_reg(psle_pkg::CFG_COLOUR_BLU, b[15:0]);
    write_reg(psle_pkg::CFG_LOBE_EXP, e[15:0]);
    settings_used++;
  endtask

  // wait at clock edges until nothing is queued, driven or expected, then let the pipe settle
  task automatic drain;
    do @(posedge clk_i);
    while (query_queue.size() != 0 || in_if.valid || color_queue.size() != 0);
    hold_sender = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    hold_sender = 1'b0;
  endtask

  function automatic lobe_query_t mk(int nx, int ny, int nz, int ix, int iy, int iz,
                                     int ox, int oy, int oz);
    lobe_query_t q;
    q = '{psle_pkg::comp_t'(nx), psle_pkg::comp_t'(ny), psle_pkg::comp_t'(nz),
          psle_pkg::comp_t'(ix), psle_pkg::comp_t'(iy), psle_pkg::comp_t'(iz),
          psle_pkg::comp_t'(ox), psle_pkg::comp_t'(oy), psle_pkg::comp_t'(oz)};
    return q;
  endfunction

  function automatic psle_pkg::comp_t small_comp();
    return psle_pkg::comp_t'($signed($urandom_range(16000)) - 8000);
  endfunction

  // about half glossy geometry near the mirror direction, the other half raw noise
  function automatic lobe_query_t rand_query();
    lobe_query_t q;
    int kind;
    psle_pkg::comp_t a, b;
    kind = $urandom_range(9);
    if (kind < 5) begin
      a = small_comp();
      b = small_comp();
      q = mk(small_comp() / 16, small_comp() / 16, 32767 - $urandom_range(300),
             a, b, 30000 - $urandom_range(6000),
             -a + small_comp() / 8, -b + small_comp() / 8, 30000 - $urandom_range(6000));
    end else begin
      q = '{psle_pkg::comp_t'($urandom), psle_pkg::comp_t'($urandom),
            psle_pkg::comp_t'($urandom), psle_pkg::comp_t'($urandom),
            psle_pkg::comp_t'($urandom), psle_pkg::comp_t'($urandom),
            psle_pkg::comp_t'($urandom), psle_pkg::comp_t'($urandom),
            psle_pkg::comp_t'($urandom)};
    end
    return q;
  endfunction

  task automatic push_directed();
    query_queue.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    query_queue.push_back(mk(0, 0, 32767, 0, 0, 32767, 0, 0, 32767));
    query_queue.push_back(mk(0, 0, 32767, 100, 0, 32767, -100, 0, 32767));
    query_queue.push_back(mk(0, 0, 32767, 0, 0, 32767, 0, 0, -32768));
    query_queue.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768));
    query_queue.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767));
    query_queue.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                             32767, 32767, 32767));
    // barely positive lobe that rounds to a zero base
    query_queue.push_back(mk(0, 0, 0, -1, 0, 0, 1, 0, 0));
    // exactly zero dot product
    query_queue.push_back(mk(0, 0, 32767, 32767, 0, 0, 0, 32767, 0));
    // unnormalized, base clamps to one
    query_queue.push_back(mk(0, 0, 32767, -20000, 0, 30000, 20000, 0, 30000));
    query_queue.push_back(mk(23170, 0, 23170, 0, 0, 32767, 32767, 0, 0));
    query_queue.push_back(mk(0, -32768, 0, 0, 16384, 0, 0, 16384, 1));
  endtask

  task automatic run_random(int count, int idle, int stall);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < count; i++) query_queue.push_back(rand_query());
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    {in_if.normal_x, in_if.normal_y, in_if.normal_z} = '0;
    {in_if.incoming_x, in_if.incoming_y, in_if.incoming_z} = '0;
    {in_if.outgoing_x, in_if.outgoing_y, in_if.outgoing_z} = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values first: gain zero gives black but still lit
    query_queue.push_back(mk(0, 0, 32767, 0, 0, 32767, 0, 0, 32767));
    drain();
    set_lobe(32768, 32768, 32768, 32768, 1);
    push_directed();
    drain();
    set_lobe(32768, 32768, 16384, 1, 0);
    push_directed();
    drain();

    // ignored writes: unused indexes and exponent bits above the field
    write_reg(CfgIdxUnusedA, 16'hFFFF);
    write_reg(CfgIdxUnusedB, 16'h1234);
    write_reg(psle_pkg::CFG_LOBE_EXP, 16'hFC03);
    settings_used++;
    run_random(200, 0, 0);

    set_lobe(65535, 65535, 0, 12345, 1023);
    run_random(200, 81, 0);
    set_lobe(32768, 32768, 32768, 32768, 2);
    run_random(200, 0, 81);
    set_lobe(0, 0, 0, 0, 0);
    run_random(100, 7, 7);
    set_lobe(40000, 30000, 32768, 65535, 7);
    run_random(200, 0, 0);
    for (int k = 0; k < 4; k++) begin
      set_lobe($urandom_range(65535), $urandom_range(32768), $urandom_range(32768),
               $urandom_range(65535), $urandom_range(64));
      run_random(150, (k % 2) ? 81 : 7, (k > 1) ? 81 : 7);
    end
    set_lobe(32768, 32768, 32768, 32768, 1023);
    run_random(100, 0, 0);

    $display("%0d queries, %0d results (%0d lit) over %0d register settings",
             queries_sent, colors_seen, lit_seen, settings_used);
    $display("idle and stall mixes covered sender, receiver, both and neither");
    if (errors == 0 && color_queue.size() == 0) begin
      $display("phong_specular_lobe_eval test passed");
    end else begin
      $display("phong_specular_lobe_eval test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/psle_pkg.sv
hw/rtl/psle_if.sv
hw/rtl/phong_specular_lobe_eval.sv
test/testbench.sv
